// ----- rtl/bfra_pkg.sv -----
// Package for the best-fit region allocator: op codes, status codes,
// field width and config register indices. No dependencies.
package bfra_pkg;
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;
  localparam logic [1:0] OP_RESERVE = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_NOTUSED = 3'd2;
  localparam logic [2:0] ST_NOTCONT = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam int FIELD_BITS = 24;
  localparam int CFG_REGS   = 2;
  localparam logic CFG_START  = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;
endpackage

// ----- rtl/best_fit_region_allocator.sv -----
// Best-fit region allocator with coalescing: free and used segment tables
// walked one entry per cycle by a small sequencer. Depends on bfra_pkg.
//
// Channel  Direction  Beat
// in       input      op, address, length (valid/ready)
// out      output     granted_address, granted_length, status (valid/ready)
// cfg      input      cfg_we, cfg_index, cfg_data (write only)
//
// An alloc, free or reserve runs from acceptance to its result through the
// free-table scan, the used-table scan, a decision step and, if a segment is
// removed or inserted, a shift pass over the free table, one entry per cycle;
// an alloc first rounds up to ALIGN. Init clears the used table likewise.
// Reset clears control state and the free count. The input is not ready while
// an item is at work; a finished result waits in the output register.
module best_fit_region_allocator
  import bfra_pkg::*;
#(
  parameter int FREE_SLOTS = 16,
  parameter int USED_SLOTS = 32,
  parameter int ALIGN      = 4,
  parameter int ADDR_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [FIELD_BITS-1:0] address,
  input  logic [FIELD_BITS-1:0] length,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FIELD_BITS-1:0] granted_address,
  output logic [FIELD_BITS-1:0] granted_length,
  output logic [2:0]            status,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [FIELD_BITS-1:0] cfg_data
);
  localparam int FI = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int FC = $clog2(FREE_SLOTS + 1);
  localparam int UI = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
  localparam int UC = $clog2(USED_SLOTS + 1);
  localparam int W  = FIELD_BITS + 1;
  localparam int SB = (ADDR_BITS >= FIELD_BITS) ? FIELD_BITS : ADDR_BITS;
  localparam logic [W-1:0] LIMIT = W'(1) << SB;
  localparam logic [W-1:0] ALIGN_W = W'(ALIGN);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_FSCAN = 4'd2;
  localparam logic [3:0] S_USCAN = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_REM   = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_ALN   = 4'd8;

  logic [FIELD_BITS-1:0] free_start [FREE_SLOTS];
  logic [FIELD_BITS-1:0] free_len   [FREE_SLOTS];
  logic [FIELD_BITS-1:0] used_start [USED_SLOTS];
  logic [FIELD_BITS-1:0] used_len   [USED_SLOTS];
  logic [USED_SLOTS-1:0] used_valid;
  logic [FC-1:0] free_count;

  logic [FIELD_BITS-1:0] region_start, region_length;
  logic [3:0] state;
  logic [1:0] cur_op;
  logic [FIELD_BITS-1:0] a_reg, len_reg;
  logic [W-1:0] size;
  logic [FC-1:0] fi;
  logic [UC-1:0] ui;
  logic best_ok, slot_ok, hit_ok, cont_ok;
  logic [FI-1:0] best;
  logic [UI-1:0] slot, hit;
  logic [FC-1:0] pos;
  logic [FI-1:0] cont;
  logic [FIELD_BITS-1:0] ins_s, ins_l;
  logic [FC-1:0] ins_pos;
  logic [FIELD_BITS-1:0] res_a, res_l;
  logic [2:0] res_st;

  logic [FI-1:0] fidx;
  logic [UI-1:0] uidx;
  logic [W-1:0] f_s, f_l;
  assign fidx  = fi[FI-1:0];
  assign uidx  = ui[UI-1:0];
  assign f_s   = {1'b0, free_start[fidx]};
  assign f_l   = {1'b0, free_len[fidx]};

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start  <= '0;
      region_length <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_START) region_start <= cfg_data;
      else region_length <= cfg_data;
    end
  end

  logic [W-1:0] lenw, aw, rend, bs, bl;
  assign lenw = {1'b0, len_reg};
  assign aw   = {1'b0, a_reg};
  assign rend = aw + lenw;
  assign bs   = {1'b0, free_start[best]};
  assign bl   = {1'b0, free_len[best]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      free_count <= '0;
      used_valid <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur_op  <= op;
            a_reg   <= address;
            len_reg <= length;
            fi <= '0;
            ui <= '0;
            best_ok <= 1'b0;
            slot_ok <= 1'b0;
            hit_ok  <= 1'b0;
            cont_ok <= 1'b0;
            pos     <= '0;
            res_a   <= '0;
            res_l   <= '0;
            res_st  <= ST_OK;
            size    <= {1'b0, length} + ALIGN_W - W'(1);
            if (op == OP_INIT) state <= S_CLEAR;
            else if (op == OP_ALLOC) state <= S_ALN;
            else state <= S_FSCAN;
          end
        end
        S_ALN: begin
          size  <= (size / ALIGN_W) * ALIGN_W;
          state <= S_FSCAN;
        end
        S_CLEAR: begin
          used_valid[uidx] <= 1'b0;
          if (ui == UC'(USED_SLOTS - 1)) begin
            free_count <= '0;
            res_a <= region_start;
            if ({1'b0, region_start} < LIMIT) begin
              if ({1'b0, region_length} > LIMIT - {1'b0, region_start})
                res_l <= FIELD_BITS'(LIMIT - {1'b0, region_start});
              else res_l <= region_length;
              if (region_length != '0) begin
                free_start[0] <= region_start;
                free_len[0] <= ({1'b0, region_length} > LIMIT - {1'b0, region_start}) ?
                               FIELD_BITS'(LIMIT - {1'b0, region_start}) : region_length;
                free_count <= FC'(1);
              end
            end
            state <= S_DONE;
          end else ui <= ui + UC'(1);
        end
        S_FSCAN: begin
          if (fi >= free_count) begin
            state <= S_USCAN;
          end else begin
            priority case (cur_op)
              OP_ALLOC: begin
                if (f_l >= size && (!best_ok || f_l < bl)) begin
                  best_ok <= 1'b1;
                  best <= fidx;
                end
              end
              OP_FREE: begin
                if (f_s <= aw) pos <= fi + FC'(1);
              end
              default: begin
                if (f_s <= aw) begin
                  cont_ok <= 1'b1;
                  cont <= fidx;
                end
              end
            endcase
            fi <= fi + FC'(1);
          end
        end
        S_USCAN: begin
          if (ui == UC'(USED_SLOTS)) begin
            state <= S_DEC;
          end else begin
            if (!used_valid[uidx] && !slot_ok) begin
              slot_ok <= 1'b1;
              slot <= uidx;
            end
            if (used_valid[uidx] && used_start[uidx] == a_reg && !hit_ok) begin
              hit_ok <= 1'b1;
              hit <= uidx;
            end
            ui <= ui + UC'(1);
          end
        end
        S_DEC: begin
          priority case (cur_op)
            OP_ALLOC: begin
              if (len_reg == '0 || !best_ok) begin
                res_st <= ST_NOFIT;
                state <= S_DONE;
              end else if (!slot_ok) begin
                res_st <= ST_FULL;
                state <= S_DONE;
              end else begin
                res_a <= free_start[best];
                res_l <= FIELD_BITS'(size);
                used_start[slot] <= free_start[best];
                used_len[slot] <= FIELD_BITS'(size);
                used_valid[slot] <= 1'b1;
                if (bl == size) begin
                  fi <= FC'(best);
                  state <= S_REM;
                end else begin
                  free_start[best] <= FIELD_BITS'(bs + size);
                  free_len[best] <= FIELD_BITS'(bl - size);
                  state <= S_DONE;
                end
              end
            end
            OP_FREE: begin
              if (!hit_ok) begin
                res_st <= ST_NOTUSED;
                state <= S_DONE;
              end else begin
                logic mprev, mnext;
                logic [FI-1:0] pp, pn;
                logic [W-1:0] hl;
                pp = FI'(pos - FC'(1));
                pn = FI'(pos);
                hl = {1'b0, used_len[hit]};
                mprev = (pos != '0) &&
                        ({1'b0, free_start[pp]} + {1'b0, free_len[pp]} == aw);
                mnext = (pos < free_count) && (aw + hl == {1'b0, free_start[pn]});
                if (!mprev && !mnext && free_count >= FC'(FREE_SLOTS)) begin
                  res_st <= ST_FULL;
                  state <= S_DONE;
                end else begin
                  used_valid[hit] <= 1'b0;
                  res_a <= a_reg;
                  res_l <= used_len[hit];
                  if (mprev && mnext) begin
                    free_len[pp] <= FIELD_BITS'({1'b0, free_len[pp]} + hl +
                                                {1'b0, free_len[pn]});
                    fi <= pos;
                    state <= S_REM;
                  end else if (mprev) begin
                    free_len[pp] <= FIELD_BITS'({1'b0, free_len[pp]} + hl);
                    state <= S_DONE;
                  end else if (mnext) begin
                    free_start[pn] <= a_reg;
                    free_len[pn] <= FIELD_BITS'({1'b0, free_len[pn]} + hl);
                    state <= S_DONE;
                  end else begin
                    ins_pos <= pos;
                    ins_s <= a_reg;
                    ins_l <= used_len[hit];
                    fi <= free_count;
                    state <= S_INS;
                  end
                end
              end
            end
            default: begin
              logic [W-1:0] cs, cl, ce;
              logic tail;
              cs = {1'b0, free_start[cont]};
              cl = {1'b0, free_len[cont]};
              ce = cs + cl;
              tail = (aw != cs) && (rend < ce);
              if (len_reg == '0 || !cont_ok || rend > ce) begin
                res_st <= ST_NOTCONT;
                state <= S_DONE;
              end else if (!slot_ok || (tail && free_count >= FC'(FREE_SLOTS))) begin
                res_st <= ST_FULL;
                state <= S_DONE;
              end else begin
                used_start[slot] <= a_reg;
                used_len[slot] <= len_reg;
                used_valid[slot] <= 1'b1;
                res_a <= a_reg;
                res_l <= len_reg;
                if (aw == cs && lenw == cl) begin
                  fi <= FC'(cont);
                  state <= S_REM;
                end else if (aw == cs) begin
                  free_start[cont] <= FIELD_BITS'(cs + lenw);
                  free_len[cont] <= FIELD_BITS'(cl - lenw);
                  state <= S_DONE;
                end else begin
                  free_len[cont] <= FIELD_BITS'(aw - cs);
                  if (tail) begin
                    ins_pos <= FC'(cont) + FC'(1);
                    ins_s <= FIELD_BITS'(rend);
                    ins_l <= FIELD_BITS'(ce - rend);
                    fi <= free_count;
                    state <= S_INS;
                  end else begin
                    state <= S_DONE;
                  end
                end
              end
            end
          endcase
        end
        S_REM: begin
          if (fi + FC'(1) >= free_count) begin
            free_count <= free_count - FC'(1);
            state <= S_DONE;
          end else begin
            free_start[fidx] <= free_start[FI'(fi + FC'(1))];
            free_len[fidx] <= free_len[FI'(fi + FC'(1))];
            fi <= fi + FC'(1);
          end
        end
        S_INS: begin
          if (fi == ins_pos) begin
            free_start[fidx] <= ins_s;
            free_len[fidx] <= ins_l;
            free_count <= free_count + FC'(1);
            state <= S_DONE;
          end else begin
            free_start[fidx] <= free_start[FI'(fi - FC'(1))];
            free_len[fidx] <= free_len[FI'(fi - FC'(1))];
            fi <= fi - FC'(1);
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid       <= 1'b1;
            granted_address <= (res_st == ST_OK) ? res_a : '0;
            granted_length  <= (res_st == ST_OK) ? res_l : '0;
            status          <= res_st;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FC'(FREE_SLOTS)) else $error("free count overflow");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("accepted while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (granted_address == '0 && granted_length == '0))
    else $error("error result carries data");
endmodule

// ----- dv/tb_best_fit_region_allocator.sv -----
// Self-checking testbench for best_fit_region_allocator: an in-bench predictor
// of the free and used tables checks every result beat. Depends on bfra_pkg.
module tb_best_fit_region_allocator;
  import bfra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFREE = 16;
  localparam int NUSED = 32;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [23:0] gaddr;
    logic [23:0] glen;
    logic [2:0]  st;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = OP_INIT;
  logic [23:0] address = '0;
  logic [23:0] length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] granted_address;
  logic [23:0] granted_length;
  logic [2:0] status;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_START;
  logic [23:0] cfg_data = '0;

  always #5 clk = ~clk;

  best_fit_region_allocator i_dut (.*);

  logic [23:0] reg_start, reg_len;
  logic [23:0] fr_start [NFREE];
  logic [23:0] fr_len [NFREE];
  int fr_cnt;
  logic [23:0] us_start [NUSED];
  logic [23:0] us_len [NUSED];
  bit us_valid [NUSED];

  grant_t pending_grants[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_ok = 0;
  int idle_pct = 34;
  bit hold_out = 1'b0;
  int idle_cycles = 0;

  function automatic void fr_remove(int i);
    for (int k = i; k + 1 < fr_cnt; k++) begin
      fr_start[k] = fr_start[k+1];
      fr_len[k] = fr_len[k+1];
    end
    fr_cnt--;
  endfunction

  function automatic void fr_insert(int i, logic [23:0] s, logic [23:0] l);
    for (int k = fr_cnt; k > i; k--) begin
      fr_start[k] = fr_start[k-1];
      fr_len[k] = fr_len[k-1];
    end
    fr_start[i] = s;
    fr_len[i] = l;
    fr_cnt++;
  endfunction

  function automatic int open_slot();
    for (int k = 0; k < NUSED; k++)
      if (!us_valid[k]) return k;
    return -1;
  endfunction

  function automatic grant_t predict_grant(logic [1:0] o, logic [23:0] a, logic [23:0] l);
    grant_t g;
    longint size, lim, fend, s64;
    int best, slot, hit, pos, c;
    bit mprev, mnext, tail;
    g = '0;
    g.st = ST_OK;
    case (o)
      OP_INIT: begin
        lim = 64'd1 << 24;
        for (int k = 0; k < NUSED; k++) us_valid[k] = 1'b0;
        fr_cnt = 0;
        g.gaddr = reg_start;
        s64 = reg_len;
        if (s64 > lim - reg_start) s64 = lim - reg_start;
        g.glen = s64[23:0];
        if (s64 > 0) fr_insert(0, reg_start, s64[23:0]);
      end
      OP_ALLOC: begin
        size = ((longint'(l) + 3) / 4) * 4;
        best = -1;
        for (int i = 0; i < fr_cnt; i++)
          if (fr_len[i] >= size && (best < 0 || fr_len[i] < fr_len[best])) best = i;
        slot = open_slot();
        if (l == 0 || best < 0) g.st = ST_NOFIT;
        else if (slot < 0) g.st = ST_FULL;
        else begin
          g.gaddr = fr_start[best];
          g.glen = size[23:0];
          us_start[slot] = g.gaddr;
          us_len[slot] = g.glen;
          us_valid[slot] = 1'b1;
          if (fr_len[best] == size) fr_remove(best);
          else begin
            fr_start[best] = fr_start[best] + size[23:0];
            fr_len[best] = fr_len[best] - size[23:0];
          end
        end
      end
      OP_FREE: begin
        hit = -1;
        for (int k = 0; k < NUSED; k++)
          if (hit < 0 && us_valid[k] && us_start[k] == a) hit = k;
        if (hit < 0) g.st = ST_NOTUSED;
        else begin
          pos = 0;
          while (pos < fr_cnt && fr_start[pos] <= a) pos++;
          mprev = pos > 0 && longint'(fr_start[pos-1]) + fr_len[pos-1] == a;
          mnext = pos < fr_cnt && longint'(a) + us_len[hit] == fr_start[pos];
          if (mprev && mnext) begin
            fr_len[pos-1] = fr_len[pos-1] + us_len[hit] + fr_len[pos];
            fr_remove(pos);
          end else if (mprev) fr_len[pos-1] = fr_len[pos-1] + us_len[hit];
          else if (mnext) begin
            fr_start[pos] = a;
            fr_len[pos] = fr_len[pos] + us_len[hit];
          end else if (fr_cnt >= NFREE) g.st = ST_FULL;
          else fr_insert(pos, a, us_len[hit]);
          if (g.st == ST_OK) begin
            us_valid[hit] = 1'b0;
            g.gaddr = a;
            g.glen = us_len[hit];
          end
        end
      end
      default: begin
        c = -1;
        for (int i = 0; i < fr_cnt; i++)
          if (fr_start[i] <= a) c = i;
        if (l == 0 || c < 0 || longint'(a) + l > longint'(fr_start[c]) + fr_len[c])
          g.st = ST_NOTCONT;
        else begin
          fend = longint'(fr_start[c]) + fr_len[c];
          tail = (a != fr_start[c]) && (longint'(a) + l < fend);
          slot = open_slot();
          if (slot < 0 || (tail && fr_cnt >= NFREE)) g.st = ST_FULL;
          else begin
            if (a == fr_start[c] && l == fr_len[c]) fr_remove(c);
            else if (a == fr_start[c]) begin
              fr_start[c] = fr_start[c] + l;
              fr_len[c] = fr_len[c] - l;
            end else begin
              fr_len[c] = a - fr_start[c];
              if (tail) begin
                s64 = fend - (longint'(a) + l);
                fr_insert(c + 1, a + l, s64[23:0]);
              end
            end
            us_start[slot] = a;
            us_len[slot] = l;
            us_valid[slot] = 1'b1;
            g.gaddr = a;
            g.glen = l;
          end
        end
      end
    endcase
    return g;
  endfunction

  task automatic send_item(logic [1:0] o, logic [23:0] a, logic [23:0] l);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    op <= o;
    address <= a;
    length <= l;
    do @(posedge clk); while (!in_ready);
    pending_grants.push_back(predict_grant(o, a, l));
    n_items++;
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_START) reg_start = val;
    else reg_len = val;
    @(posedge clk);
  endtask

  task automatic set_region(logic [23:0] s, logic [23:0] l);
    drain();
    write_reg(CFG_START, s);
    write_reg(CFG_LENGTH, l);
  endtask

  // Random address, often a live segment start or near the region start, so frees and reserves hit often.
  function automatic logic [23:0] pick_addr();
    int k;
    k = $urandom_range(NUSED - 1);
    case ($urandom_range(3))
      0: if (us_valid[k]) return us_start[k];
      1: if (fr_cnt > 0) return fr_start[$urandom_range(fr_cnt - 1)];
      2: return 24'(reg_start + $urandom_range(255));
      default: ;
    endcase
    return 24'($urandom());
  endfunction

  task automatic random_mix(int count, int maxlen);
    logic [1:0] o;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(19))
        0: o = OP_INIT;
        1, 2, 3, 4, 5, 6, 7: o = OP_ALLOC;
        8, 9, 10, 11, 12, 13: o = OP_FREE;
        default: o = OP_RESERVE;
      endcase
      send_item(o, pick_addr(),
                ($urandom_range(15) == 0) ? 24'($urandom()) : 24'($urandom_range(maxlen)));
    end
  endtask

  task automatic test_directed();
    set_region(24'h000100, 24'h000400);
    send_item(OP_ALLOC, 0, 1);
    send_item(OP_INIT, 0, 0);
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_ALLOC, 0, 24'hFFFFFF);
    send_item(OP_ALLOC, 0, 5);
    send_item(OP_ALLOC, 0, 16);
    send_item(OP_ALLOC, 0, 8);
    send_item(OP_FREE, 24'h000108, 0);
    send_item(OP_FREE, 24'h000108, 0);
    send_item(OP_FREE, 24'h000100, 0);
    send_item(OP_FREE, 24'h000118, 0);
    send_item(OP_RESERVE, 24'h000200, 24'h10);
    send_item(OP_RESERVE, 24'h000100, 24'h10);
    send_item(OP_RESERVE, 24'h000110, 24'h3F0);
    send_item(OP_RESERVE, 24'h000000, 24'h10);
    send_item(OP_RESERVE, 24'h000300, 0);
    send_item(OP_RESERVE, 24'hFFFFFF, 24'hFFFFFF);
    for (int k = 0; k < 8; k++) send_item(OP_ALLOC, 0, 4);
  endtask

  task automatic test_region_edges();
    set_region(24'hFFFF00, 24'hFFFFFF);
    send_item(OP_INIT, 0, 0);
    send_item(OP_ALLOC, 0, 24'h100);
    set_region(24'h000000, 24'h000000);
    send_item(OP_INIT, 0, 0);
    send_item(OP_ALLOC, 0, 4);
    set_region(24'h000000, 24'hFFFFFF);
    send_item(OP_INIT, 0, 0);
    send_item(OP_ALLOC, 0, 24'hFFFFFD);
    send_item(OP_FREE, 0, 0);
  endtask

  task automatic test_table_full();
    set_region(24'h001000, 24'h000800);
    send_item(OP_INIT, 0, 0);
    for (int k = 0; k < 34; k++) send_item(OP_ALLOC, 0, 8);
    for (int k = 0; k < 32; k += 2) send_item(OP_FREE, 24'(24'h001000 + 8 * k), 0);
    send_item(OP_FREE, 24'(24'h001000 + 8 * 31), 0);
    send_item(OP_INIT, 0, 0);
    for (int k = 0; k < 17; k++)
      send_item(OP_RESERVE, 24'(24'h001004 + 16 * k), 4);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
      random_mix(12, 64);
    join
    drain();
  endtask

  task automatic test_random();
    set_region(24'h000040, 24'h000300);
    send_item(OP_INIT, 0, 0);
    random_mix(500, 64);
    set_region(24'($urandom()), 24'($urandom_range(4096)));
    send_item(OP_INIT, 0, 0);
    idle_pct = 0;
    random_mix(300, 300);
    idle_pct = 34;
    set_region(24'($urandom()), 24'($urandom()));
    send_item(OP_INIT, 0, 0);
    random_mix(750, 4096);
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_out && (idle_pct == 0 || $urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_grants.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (exp_g.st == ST_OK) n_ok++;
        if (granted_address !== exp_g.gaddr) begin
          $error("granted_address exp %h got %h", exp_g.gaddr, granted_address);
          errors++;
        end
        if (granted_length !== exp_g.glen) begin
          $error("granted_length exp %h got %h", exp_g.glen, granted_length);
          errors++;
        end
        if (status !== exp_g.st) begin
          $error("status exp %0d got %0d", exp_g.st, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    reg_start = '0;
    reg_len = '0;
    fr_cnt = 0;
    foreach (us_valid[k]) us_valid[k] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (40) @(posedge clk);
    test_directed();
    test_region_edges();
    test_table_full();
    test_backpressure();
    test_random();
    drain();
    $display("Covered %0d items, %0d results (%0d granted) over init, alloc, free, reserve.",
             n_items, n_results, n_ok);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/bfra_pkg.sv
rtl/best_fit_region_allocator.sv
dv/tb_best_fit_region_allocator.sv
